>>> rtl/stl_pkg.sv
package stl_pkg;

  localparam int COORD_BITS  = 14;
  localparam int COUNT_BITS  = 7;
  localparam int INDEX_BITS  = 6;
  localparam int RATIO_BITS  = 17;
  localparam int SHAPE_BITS  = 4;
  localparam int MAX_TILES   = 64;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_DEPTH = 64;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam logic [RATIO_BITS-1:0] RATIO_ONE    = 17'h10000;
  localparam logic [COORD_BITS-1:0] RESET_WIDTH  = 14'd1920;
  localparam logic [COORD_BITS-1:0] RESET_HEIGHT = 14'd1080;
  localparam logic [RATIO_BITS-1:0] RESET_RATIO  = 17'd32768;

  typedef enum logic [1:0] {
    MODE_MASTER  = 2'd0,
    MODE_GRID    = 2'd1,
    MODE_MONOCLE = 2'd2,
    MODE_EVEN    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_RATIO  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    mode_t                  layout_mode;
    logic [COORD_BITS-1:0]  screen_width;
    logic [COORD_BITS-1:0]  screen_height;
    logic [RATIO_BITS-1:0]  master_ratio;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] tile_count;
    logic [INDEX_BITS-1:0] tile_index;
  } req_t;

  typedef struct packed {
    logic                  placed;
    logic [COORD_BITS-1:0] left_x;
    logic [COORD_BITS-1:0] top_y;
    logic [COORD_BITS-1:0] tile_width;
    logic [COORD_BITS-1:0] tile_height;
  } rsp_t;

endpackage

>>> rtl/stl_regs.sv
module stl_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [stl_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [stl_pkg::DATA_BITS-1:0]  pwdata,
  output logic [stl_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output stl_pkg::cfg_t                  cfg
);
  import stl_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layout_mode   <= MODE_MASTER;
      cfg.screen_width  <= RESET_WIDTH;
      cfg.screen_height <= RESET_HEIGHT;
      cfg.master_ratio  <= RESET_RATIO;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:   cfg.layout_mode   <= mode_t'(pwdata[1:0]);
        REG_WIDTH:  cfg.screen_width  <= pwdata[COORD_BITS-1:0];
        REG_HEIGHT: cfg.screen_height <= pwdata[COORD_BITS-1:0];
        REG_RATIO:  cfg.master_ratio  <= pwdata[RATIO_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = DATA_BITS'(cfg.layout_mode);
      REG_WIDTH:  prdata = DATA_BITS'(cfg.screen_width);
      REG_HEIGHT: prdata = DATA_BITS'(cfg.screen_height);
      REG_RATIO:  prdata = DATA_BITS'(cfg.master_ratio);
    endcase
  end

endmodule

>>> rtl/screen_tile_layout.sv
// Tile rectangle lookup for a tiled screen layout.
// Request channel (req_valid / req_stall / req) carries a tile count and a
// tile index; the response channel (rsp_valid / rsp_stall / rsp) returns one
// rectangle per request: placed flag, left/top edge, width and height.
// Mode, screen size and master ratio sit in APB registers at byte offsets
// 0, 4, 8 and 12; write them only while no request is in flight.
// The datapath is six register stages: count clamp and grid shape,
// reciprocal multiply, back-multiply, remainder correction, offset multiply
// and the output register; one request is taken every cycle while req_stall
// is low.
// The whole pipeline holds while rsp_valid and rsp_stall are both high;
// req_stall is raised in exactly those cycles, so nothing is lost or
// repeated and the response payload stays put.
// Reset clears all valid bits and loads the default registers: master-stack
// mode, 1920 x 1080 screen, ratio one half.
module screen_tile_layout (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [stl_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [stl_pkg::DATA_BITS-1:0]  pwdata,
  output logic [stl_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  stl_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output stl_pkg::rsp_t                  rsp
);
  import stl_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int NB = COUNT_BITS;
  localparam int IB = INDEX_BITS;
  localparam int SB = SHAPE_BITS;
  localparam int PW = CW + RATIO_BITS;
  localparam int PI = IB + RATIO_BITS;
  localparam int GB = 3;

  // cols = ceil(sqrt n) from constant compares; rows is cols or cols - 1
  function automatic logic [2*SB-1:0] grid_shape(input logic [NB-1:0] n);
    logic [SB-1:0] c;
    logic [NB-1:0] t;
    c = SB'(1);
    t = '0;
    for (int k = 1; k < 8; k++) begin
      if (n > NB'(k * k)) begin
        c = SB'(k + 1);
        t = NB'(k * (k + 1));
      end
    end
    return {c, (n > t) ? c : c - SB'(1)};
  endfunction

  cfg_t cfg;

  stl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [RATIO_BITS-1:0] recip_tab [RECIP_DEPTH];

  for (genvar k = 0; k < RECIP_DEPTH; k++) begin : g_recip
    localparam int DIV = (k == 0) ? 1 : k;
    localparam logic [RATIO_BITS-1:0] RV = RATIO_BITS'((1 << RECIP_SHIFT) / DIV);
    assign recip_tab[k] = RV;
  end

  logic [CW-1:0] w;
  logic [CW-1:0] h;
  logic          adv;

  assign w         = cfg.screen_width;
  assign h         = cfg.screen_height;
  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;

  // stage 1: count clamp, grid shape
  logic [NB-1:0]   n_sat;
  logic [2*SB-1:0] shape;
  logic            placed_in;

  assign n_sat     = (req.tile_count > NB'(MAX_TILES)) ? NB'(MAX_TILES) : req.tile_count;
  assign shape     = grid_shape(n_sat);
  assign placed_in = (n_sat != '0) && (NB'(req.tile_index) < n_sat);

  logic          s1_valid;
  logic [NB-1:0] s1_n;
  logic [IB-1:0] s1_i;
  logic [SB-1:0] s1_cols;
  logic [SB-1:0] s1_rows;
  logic [IB-1:0] s1_dsh;
  logic          s1_placed;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_n      <= n_sat;
      s1_i      <= req.tile_index;
      s1_cols   <= shape[2*SB-1:SB];
      s1_rows   <= shape[SB-1:0];
      s1_dsh    <= IB'(n_sat - NB'(1));
      s1_placed <= placed_in;
    end
  end

  // stage 2: reciprocal multiplies
  logic [RATIO_BITS-1:0] ratio_sat;
  logic [PW-1:0]         p_mw;
  logic [PW-1:0]         p_sh;
  logic [PW-1:0]         p_cw;
  logic [PW-1:0]         p_ch;
  logic [PI-1:0]         p_row;

  assign ratio_sat = (cfg.master_ratio > RATIO_ONE) ? RATIO_ONE : cfg.master_ratio;
  assign p_mw      = PW'(w) * PW'(ratio_sat);
  assign p_sh      = PW'(h) * PW'(recip_tab[s1_dsh]);
  assign p_cw      = PW'(w) * PW'(recip_tab[IB'(s1_cols)]);
  assign p_ch      = PW'(h) * PW'(recip_tab[IB'(s1_rows)]);
  assign p_row     = PI'(s1_i) * PI'(recip_tab[IB'(s1_cols)]);

  logic          s2_valid;
  logic [NB-1:0] s2_n;
  logic [IB-1:0] s2_i;
  logic [SB-1:0] s2_cols;
  logic [SB-1:0] s2_rows;
  logic [IB-1:0] s2_dsh;
  logic          s2_placed;
  logic [CW-1:0] s2_mw;
  logic [CW-1:0] s2_q_sh;
  logic [CW-1:0] s2_q_cw;
  logic [CW-1:0] s2_q_ch;
  logic [IB-1:0] s2_q_row;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_n      <= s1_n;
      s2_i      <= s1_i;
      s2_cols   <= s1_cols;
      s2_rows   <= s1_rows;
      s2_dsh    <= s1_dsh;
      s2_placed <= s1_placed;
      s2_mw     <= p_mw[RECIP_SHIFT +: CW];
      s2_q_sh   <= p_sh[RECIP_SHIFT +: CW];
      s2_q_cw   <= p_cw[RECIP_SHIFT +: CW];
      s2_q_ch   <= p_ch[RECIP_SHIFT +: CW];
      s2_q_row  <= p_row[RECIP_SHIFT +: IB];
    end
  end

  // stage 3: quotient estimate times divisor
  logic          s3_valid;
  logic [NB-1:0] s3_n;
  logic [IB-1:0] s3_i;
  logic [SB-1:0] s3_cols;
  logic [SB-1:0] s3_rows;
  logic [IB-1:0] s3_dsh;
  logic          s3_placed;
  logic [CW-1:0] s3_mw;
  logic [CW-1:0] s3_q_sh;
  logic [CW-1:0] s3_q_cw;
  logic [CW-1:0] s3_q_ch;
  logic [IB-1:0] s3_q_row;
  logic [CW-1:0] s3_b_sh;
  logic [CW-1:0] s3_b_cw;
  logic [CW-1:0] s3_b_ch;
  logic [IB-1:0] s3_b_row;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_n      <= s2_n;
      s3_i      <= s2_i;
      s3_cols   <= s2_cols;
      s3_rows   <= s2_rows;
      s3_dsh    <= s2_dsh;
      s3_placed <= s2_placed;
      s3_mw     <= s2_mw;
      s3_q_sh   <= s2_q_sh;
      s3_q_cw   <= s2_q_cw;
      s3_q_ch   <= s2_q_ch;
      s3_q_row  <= s2_q_row;
      s3_b_sh   <= CW'((CW + IB)'(s2_q_sh) * (CW + IB)'(s2_dsh));
      s3_b_cw   <= CW'((CW + SB)'(s2_q_cw) * (CW + SB)'(s2_cols));
      s3_b_ch   <= CW'((CW + SB)'(s2_q_ch) * (CW + SB)'(s2_rows));
      s3_b_row  <= IB'((IB + SB)'(s2_q_row) * (IB + SB)'(s2_cols));
    end
  end

  // stage 4: remainder check, one correction step
  logic [CW-1:0] rem_sh;
  logic [CW-1:0] rem_cw;
  logic [CW-1:0] rem_ch;
  logic [IB-1:0] rem_row;
  logic          inc_row;

  assign rem_sh  = h - s3_b_sh;
  assign rem_cw  = w - s3_b_cw;
  assign rem_ch  = h - s3_b_ch;
  assign rem_row = s3_i - s3_b_row;
  assign inc_row = rem_row >= IB'(s3_cols);

  logic          s4_valid;
  logic [NB-1:0] s4_n;
  logic [IB-1:0] s4_i;
  logic          s4_placed;
  logic [CW-1:0] s4_mw;
  logic [CW-1:0] s4_sh;
  logic [CW-1:0] s4_cw;
  logic [CW-1:0] s4_ch;
  logic [GB-1:0] s4_grow;
  logic [GB-1:0] s4_gcol;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_n      <= s3_n;
      s4_i      <= s3_i;
      s4_placed <= s3_placed;
      s4_mw     <= s3_mw;
      s4_sh     <= s3_q_sh + CW'(rem_sh >= CW'(s3_dsh));
      s4_cw     <= s3_q_cw + CW'(rem_cw >= CW'(s3_cols));
      s4_ch     <= s3_q_ch + CW'(rem_ch >= CW'(s3_rows));
      s4_grow   <= GB'(s3_q_row + IB'(inc_row));
      s4_gcol   <= inc_row ? GB'(rem_row - IB'(s3_cols)) : GB'(rem_row);
    end
  end

  // stage 5: offsets
  logic          s5_valid;
  logic [NB-1:0] s5_n;
  logic [IB-1:0] s5_i;
  logic          s5_placed;
  logic [CW-1:0] s5_mw;
  logic [CW-1:0] s5_sh;
  logic [CW-1:0] s5_cw;
  logic [CW-1:0] s5_ch;
  logic [CW-1:0] s5_y_sh;
  logic [CW-1:0] s5_gx;
  logic [CW-1:0] s5_gy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_n      <= s4_n;
      s5_i      <= s4_i;
      s5_placed <= s4_placed;
      s5_mw     <= s4_mw;
      s5_sh     <= s4_sh;
      s5_cw     <= s4_cw;
      s5_ch     <= s4_ch;
      s5_y_sh   <= CW'((CW + IB)'(s4_i - IB'(1)) * (CW + IB)'(s4_sh));
      s5_gx     <= CW'((CW + GB)'(s4_gcol) * (CW + GB)'(s4_cw));
      s5_gy     <= CW'((CW + GB)'(s4_grow) * (CW + GB)'(s4_ch));
    end
  end

  // stage 6: mode select into the output register
  logic [CW-1:0] w2;
  logic [CW-1:0] h2;
  rsp_t          grid_rect;
  rsp_t          rsp_next;

  assign w2 = w >> 1;
  assign h2 = h >> 1;

  always_comb begin
    grid_rect = '{placed: 1'b1, left_x: s5_gx, top_y: s5_gy,
                  tile_width: s5_cw, tile_height: s5_ch};
    rsp_next  = '{placed: 1'b1, left_x: '0, top_y: '0, tile_width: w, tile_height: h};
    unique case (cfg.layout_mode)
      MODE_MASTER: begin
        if (s5_i == '0) begin
          rsp_next.tile_width = s5_mw;
        end else begin
          rsp_next.left_x      = s5_mw;
          rsp_next.top_y       = s5_y_sh;
          rsp_next.tile_width  = w - s5_mw;
          rsp_next.tile_height = s5_sh;
        end
      end
      MODE_GRID: rsp_next = grid_rect;
      MODE_MONOCLE: ;
      MODE_EVEN: begin
        case (s5_n)
          NB'(1): ;
          NB'(2): begin
            rsp_next.left_x     = s5_i[0] ? w2 : '0;
            rsp_next.tile_width = w2;
          end
          NB'(3): begin
            rsp_next.tile_width = w2;
            if (s5_i != '0) begin
              rsp_next.left_x      = w2;
              rsp_next.top_y       = s5_i[1] ? h2 : '0;
              rsp_next.tile_height = h2;
            end
          end
          NB'(4): begin
            rsp_next.left_x      = s5_i[0] ? w2 : '0;
            rsp_next.top_y       = s5_i[1] ? h2 : '0;
            rsp_next.tile_width  = w2;
            rsp_next.tile_height = h2;
          end
          default: rsp_next = grid_rect;
        endcase
      end
    endcase
    if (!s5_placed) rsp_next = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= req_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      rsp_valid <= s5_valid;
    end
  end

endmodule
